// File: hdl/ren_pkg.sv
// ----------------------------------------------------------------------------
// ren_pkg - shared types and constants
// Register indexes, counter widths and the configuration bundle that the
// register block hands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ren_pkg;

	// histogram entries, E and the count above E are all this wide
	localparam int unsigned CNT_W = 13;
	localparam logic [CNT_W-1:0] CNT_MAX = 13'd8191;

	localparam int unsigned VAL_W = 16;

	// apb register map, one register every four bytes
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;
	localparam logic REG_RUN_LENGTH = 1'b0;
	localparam logic REG_CUMULATIVE = 1'b1;

	localparam logic [CNT_W-1:0] RUN_LENGTH_RST = 13'd4096;

	typedef struct packed {
		logic [CNT_W-1:0] run_length;
		logic             cumulative_mode;
	} cfg_t;

endpackage

`default_nettype wire

// File: hdl/running_eddington_number_unit.sv
// ----------------------------------------------------------------------------
// running_eddington_number_unit - running Eddington number
// Keeps E over a stream of ride values using a histogram held in memory.
// ----------------------------------------------------------------------------
// flow: a word passes the holding stage, the commit stage and the result
// register; a new word is read from the histogram only after the last one
//   has been written back (read at issue, modify and write at commit)
// reset: E, the count above E and the control are cleared at once; a clearing
//   pass then zeroes every histogram entry with s_tready low
`default_nettype none

module running_eddington_number_unit #(
	parameter int MAX_RUN = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input stream
	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	input  wire logic [15:0]                   s_tdata,   // [15:0] ride_value
	input  wire logic                          s_tlast,   // last_item
	// result stream
	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	output      logic [15:0]                   m_tdata,   // [12:0] eddington_value, [15:13] zero
	output      logic                          m_tlast,   // final_result
	// configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ren_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [ren_pkg::PDATA_W-1:0]   pwdata,
	output      logic [ren_pkg::PDATA_W-1:0]   prdata,
	output      logic                          pready
);
	import ren_pkg::*;

	localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

	cfg_t cfg;

	// control and running state
	logic             clr_active_q;
	logic [AW-1:0]    clr_addr_q;
	logic [CNT_W-1:0] e_q;        // current Eddington number
	logic [CNT_W-1:0] cnt_q;      // values above E not yet absorbed

	// input holding stage
	logic             s0_valid_q;
	logic [VAL_W-1:0] s0_val_q;
	logic             s0_last_q;

	// commit stage, waits for the histogram read data
	logic             s1_valid_q;
	logic [VAL_W-1:0] s1_val_s1;
	logic             s1_last_s1;

	// result register
	logic             out_valid_q;
	logic [CNT_W-1:0] out_e_q;
	logic             out_last_q;

	logic             issue;
	logic             commit;
	logic             emit;
	logic [CNT_W:0]   e_next;      // E + 1, one bit wider
	logic [CNT_W-1:0] rd_v;        // histogram at the ride value
	logic [CNT_W-1:0] rd_n;        // histogram at E + 1
	logic [14:0]      v15;
	logic             above;       // value strictly above E
	logic             record;      // value goes into the histogram
	logic [CNT_W-1:0] hist_inc;
	logic [CNT_W-1:0] cnt_inc;
	logic             bump;
	logic             next_in_range;
	logic [CNT_W-1:0] h_next;
	logic [CNT_W-1:0] cnt_new;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [CNT_W-1:0] mem_wdata;

	ren_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake: the holding stage frees itself whenever it issues
	assign issue    = s0_valid_q & ~s1_valid_q & ~clr_active_q;
	assign s_tready = ~clr_active_q & (~s0_valid_q | issue);
	assign emit     = cfg.cumulative_mode | s1_last_s1;
	// commit stalls only when a result has nowhere to go
	assign commit   = s1_valid_q & (~emit | ~out_valid_q | m_tready);

	assign e_next = {1'b0, e_q} + {{CNT_W{1'b0}}, 1'b1};

	ren_hist_mem #(
		.DEPTH (MAX_RUN),
		.AW    (AW),
		.DW    (CNT_W)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.re      (issue),
		.raddr_a (AW'(s0_val_q[14:0])),
		.raddr_b (AW'(e_next)),
		.rdata_a (rd_v),
		.rdata_b (rd_n)
	);

	// read-modify-write at commit; E and the count are untouched since issue
	assign v15      = s1_val_s1[14:0];
	assign above    = ~s1_val_s1[15] & (v15 > {2'b00, e_q});
	assign record   = above & (v15 < {2'b00, cfg.run_length})
		& ({17'd0, v15} < 32'(MAX_RUN));
	assign hist_inc = (rd_v < CNT_MAX) ? rd_v + 13'd1 : rd_v;
	assign cnt_inc  = (cnt_q < CNT_MAX) ? cnt_q + 13'd1 : cnt_q;
	assign bump     = above & (cnt_inc > e_q) & (e_q < CNT_MAX);

	// entry at the new E, forwarded when this very word just bumped it
	assign next_in_range = (e_next < {1'b0, cfg.run_length})
		& ({{(31-CNT_W){1'b0}}, e_next} < 32'(MAX_RUN));

	always_comb begin
		if (!next_in_range) begin
			h_next = '0;
		end else if (record && (v15 == 15'(e_next))) begin
			h_next = hist_inc;
		end else begin
			h_next = rd_n;
		end
	end

	always_comb begin
		if (bump) begin
			cnt_new = (h_next > cnt_inc) ? '0 : cnt_inc - h_next;
		end else if (above) begin
			cnt_new = cnt_inc;
		end else begin
			cnt_new = cnt_q;
		end
	end

	// the clearing pass owns the write port until it ends
	assign mem_we    = clr_active_q | (commit & record);
	assign mem_waddr = clr_active_q ? clr_addr_q : AW'(v15);
	assign mem_wdata = clr_active_q ? '0 : hist_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(MAX_RUN - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q   <= '0;
			cnt_q <= '0;
		end else if (commit) begin
			e_q   <= bump ? e_q + 13'd1 : e_q;
			cnt_q <= cnt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s0_valid_q <= 1'b1;
		end else if (issue) begin
			s0_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			s0_val_q  <= s_tdata;
			s0_last_q <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (issue) begin
			s1_valid_q <= 1'b1;
		end else if (commit) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			s1_val_s1  <= s0_val_q;
			s1_last_s1 <= s0_last_q;
		end
	end

	// result register, refilled in the cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit && emit) begin
			out_e_q    <= bump ? e_q + 13'd1 : e_q;
			out_last_q <= s1_last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_e_q};
	assign m_tlast  = out_last_q;

	// E only ever steps up by one
	a_e_step: assert property (@(posedge clk) disable iff (!arst_n)
		(e_q != $past(e_q)) |-> (e_q == $past(e_q) + 13'd1))
		else $error("eddington number moved by more than one");

	// no word is taken or in flight while the histogram is being cleared
	a_clr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> (!s_tready && !s0_valid_q && !s1_valid_q))
		else $error("word in flight during clearing pass");

	// a word waiting on the commit stage stays there until committed
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !commit) |=> (s1_valid_q && $stable(s1_val_s1)))
		else $error("commit stage lost a word");

	// a read is never issued while a write-back is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> !s1_valid_q)
		else $error("histogram read overlaps pending write-back");

endmodule

`default_nettype wire

// File: hdl/ren_hist_mem.sv
// ----------------------------------------------------------------------------
// ren_hist_mem - histogram store
// One write port and two read ports, read data registered and held until
// the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module ren_hist_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 13
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr_a,
	input  wire logic [AW-1:0] raddr_b,
	output      logic [DW-1:0] rdata_a,
	output      logic [DW-1:0] rdata_b
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

// File: hdl/ren_cfg.sv
// ----------------------------------------------------------------------------
// ren_cfg - configuration registers
// APB slave holding run length and cumulative mode.
// ----------------------------------------------------------------------------
`default_nettype none

module ren_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ren_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [ren_pkg::PDATA_W-1:0]   pwdata,
	output      logic [ren_pkg::PDATA_W-1:0]   prdata,
	output      logic                          pready,
	output      ren_pkg::cfg_t                 cfg
);
	import ren_pkg::*;

	logic [CNT_W-1:0] run_length_q;
	logic             cumulative_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q <= RUN_LENGTH_RST;
			cumulative_q <= 1'b0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_RUN_LENGTH: run_length_q <= pwdata[CNT_W-1:0];
				REG_CUMULATIVE: cumulative_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_RUN_LENGTH: prdata = {{(PDATA_W-CNT_W){1'b0}}, run_length_q};
			REG_CUMULATIVE: prdata = {{(PDATA_W-1){1'b0}}, cumulative_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.run_length      = run_length_q;
	assign cfg.cumulative_mode = cumulative_q;

endmodule

`default_nettype wire

// File: dv/tb_running_eddington_number_unit.sv
// ----------------------------------------------------------------------------
// tb_running_eddington_number_unit - running Eddington number testbench
// Streams ride values into the unit under a range of register settings and
// idle patterns. A scoreboard keeps its own histogram, E and count above E,
// predicts every result word and checks the output stream against it.
// ----------------------------------------------------------------------------

class eddington_scoreboard;

	localparam int HIST_DEPTH = 4096;
	localparam int SAT_LIMIT = 8191;

	typedef struct packed {
		logic [ren_pkg::CNT_W-1:0] number;
		logic                      final_flag;
	} edd_result_t;

	// predictor state and register copies
	int          ride_histogram [HIST_DEPTH];
	int          e_number;
	int          count_above;
	int          run_length;
	bit          cumulative;
	edd_result_t expected_q [$];
	int          error_count;

	function new();
		foreach (ride_histogram[i])
			ride_histogram[i] = 0;
		e_number = 0;
		count_above = 0;
		run_length = 4096;
		cumulative = 1'b0;
		error_count = 0;
	endfunction

	function void flag(string msg);
		if (error_count < 10)
			$display("%s", msg);
		error_count++;
	endfunction

	// an accepted input word updates E and may queue one result
	function void note_ride_value(logic [15:0] raw, logic last_word);
		int          val;
		int          h;
		edd_result_t res;
		val = int'($signed(raw));
		if (val > e_number) begin
			if (val < run_length && val < HIST_DEPTH && ride_histogram[val] < SAT_LIMIT)
				ride_histogram[val]++;
			if (count_above < SAT_LIMIT)
				count_above++;
			if (count_above > e_number && e_number < SAT_LIMIT) begin
				e_number++;
				// entries outside the recorded range read as zero
				h = (e_number < run_length && e_number < HIST_DEPTH) ?
					ride_histogram[e_number] : 0;
				count_above = (h > count_above) ? 0 : count_above - h;
			end
		end
		if (cumulative || last_word) begin
			res.number = e_number[ren_pkg::CNT_W-1:0];
			res.final_flag = last_word;
			expected_q.push_back(res);
		end
	endfunction

	function void check_result(logic [ren_pkg::CNT_W-1:0] number, logic final_flag);
		edd_result_t want;
		if (expected_q.size() == 0) begin
			flag($sformatf("result word with none expected: E %0d last %0b",
				number, final_flag));
			return;
		end
		want = expected_q.pop_front();
		if (want.number !== number)
			flag($sformatf("eddington_value mismatch: expected %0d, got %0d",
				want.number, number));
		if (want.final_flag !== final_flag)
			flag($sformatf("final_result mismatch: expected %0b, got %0b",
				want.final_flag, final_flag));
	endfunction

endclass

module tb_running_eddington_number_unit;

	import ren_pkg::*;

	localparam int  MAX_RUN     = 4096;
	localparam int  DRAIN_CYCLES = 12;   // covers words still in the unit, with margin
	localparam int  HOLD_CYCLES = 80;    // long receiver hold-off
	// clearing pass plus several times the slowest run
	localparam time LIMIT_TIME  = 1_000_000;

	// directed words: extremes, negatives, run length edges, last flags
	localparam int DIRECTED_N = 25;
	localparam logic [15:0] DIRECTED_VALUES [DIRECTED_N] = '{
		16'h8000, 16'hffff, 16'h0000, 16'h7fff, 16'd1,
		16'd2,    16'd2,    16'd3,    16'd3,    16'd3,
		16'd4096, 16'd4095, 16'd8191, 16'h4000, 16'd5,
		16'd5,    16'd5,    16'd5,    16'd1,    16'd6,
		16'd7,    16'd6,    16'd7,    16'd8,    16'h8001
	};
	// bit i marks word i as the last of the run
	localparam logic [DIRECTED_N-1:0] DIRECTED_LAST = 25'b1_0100_0100_0000_0000_0000_0000;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	wire                 s_tready;
	logic [15:0]         s_tdata;    // [15:0] ride_value
	logic                s_tlast;    // last_item
	wire                 m_tvalid;
	logic                m_tready;
	wire  [15:0]         m_tdata;    // [12:0] eddington_value, [15:13] zero
	wire                 m_tlast;    // final_result
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	wire  [PDATA_W-1:0]  prdata;
	wire                 pready;

	eddington_scoreboard sb = new();

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	bit hold_request = 1'b0;

	running_eddington_number_unit #(
		.MAX_RUN(MAX_RUN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit, well beyond the slowest passing run
	initial begin
		#(LIMIT_TIME);
		$display("simulation failed");
		$finish;
	end

	// receiver: random back-pressure, or a long hold-off when asked
	initial begin
		int hold_left;
		m_tready <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// result monitor, values sampled as they stood before the edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata[CNT_W-1:0], m_tlast);
	end

	// register write: setup then access, held until pready
	task automatic apb_write(input logic reg_index, input logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({reg_index, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_index == REG_RUN_LENGTH)
			sb.run_length = int'(value[CNT_W-1:0]);
		else
			sb.cumulative = value[0];
		// a spare cycle so back-to-back writes never clash on psel
		@(posedge clk);
	endtask

	// offer one word, with random gaps first, and note it once taken
	task automatic send_word(input logic [15:0] value, input logic last_word);
		while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tlast <= last_word;
		do @(posedge clk); while (!s_tready);
		sb.note_ride_value(value, last_word);
	endtask

	// sender pauses until every predicted result word is back
	task automatic wait_results_in();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
	endtask

	// idle point: results in, then room for words that give no result
	task automatic wait_drained();
		wait_results_in();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// mostly values just above E so that E keeps climbing, plus noise
	function automatic logic [15:0] next_ride_value();
		int pick;
		pick = $urandom_range(99);
		if (pick < 55)
			return 16'(sb.e_number + int'($urandom_range(24, 1)));
		else if (pick < 70)
			return 16'($urandom_range(sb.e_number, 0));
		else if (pick < 80)
			return 16'(-int'($urandom_range(32768, 1)));
		else if (pick < 90)
			return 16'($urandom_range(65535, 0));
		else
			// around the run length edge
			return 16'(sb.run_length - 1 + int'($urandom_range(2, 0)));
	endfunction

	task automatic run_phase(input int rl, input bit cum, input int tx_pct, input int rx_pct,
		input int n_words, input bit hold, input bit mid_pause);
		logic last_word;
		wait_drained();
		apb_write(REG_RUN_LENGTH, PDATA_W'(rl));
		apb_write(REG_CUMULATIVE, PDATA_W'(cum));
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		// receiver stalls long while the sender keeps offering words
		if (hold)
			hold_request = 1'b1;
		for (int i = 0; i < n_words; i++) begin
			if (mid_pause && i == n_words / 2)
				wait_results_in();
			// last words are commoner when only they give a result
			last_word = cum ? ($urandom_range(9) == 0) : ($urandom_range(5) == 0);
			send_word(next_ride_value(), last_word);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, every E visible in cumulative mode
		wait_drained();
		apb_write(REG_RUN_LENGTH, PDATA_W'(4096));
		apb_write(REG_CUMULATIVE, PDATA_W'(1));
		tx_idle_pct = 6;
		rx_idle_pct = 61;
		for (int i = 0; i < DIRECTED_N; i++)
			send_word(DIRECTED_VALUES[i], DIRECTED_LAST[i]);

		// random part: sender idles lightly, receiver heavily
		run_phase(4096, 1'b0, 6, 61, 90, 1'b0, 1'b0);
		run_phase(1, 1'b1, 6, 61, 60, 1'b0, 1'b0);
		// the other way round; run length beyond the histogram, then zero
		run_phase(8191, 1'b1, 61, 6, 90, 1'b0, 1'b1);
		run_phase(0, 1'b0, 61, 6, 60, 1'b0, 1'b0);
		// no idling; long receiver hold-off fills the unit up
		run_phase(37, 1'b1, 0, 0, 90, 1'b1, 1'b0);
		run_phase(4096, 1'b1, 0, 0, 130, 1'b0, 1'b0);

		wait_drained();
		if (sb.error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
hdl/ren_pkg.sv
hdl/ren_hist_mem.sv
hdl/ren_cfg.sv
hdl/running_eddington_number_unit.sv
dv/tb_running_eddington_number_unit.sv
